@@ src/segmented_message_ring_queue_assert.svh @@
// Assertion macros for the segmented message ring queue.
// Needs no package; included by the files that carry concurrent assertions.
`ifndef SEGMENTED_MESSAGE_RING_QUEUE_ASSERT_SVH
`define SEGMENTED_MESSAGE_RING_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMRQ_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMRQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/smrq_pkg.sv @@
// Package of the segmented message ring queue: sizes, codes, request and
// result types, and byte helpers. Depends on nothing.
package smrq_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int NODE_BYTES    = 8;
  localparam int IDX_W         = $clog2(QUEUE_DEPTH);
  localparam int SIZE_W        = IDX_W + 1;
  localparam int DATA_W        = 64;
  localparam int LEN_W         = 9;
  localparam int VB_W          = 4;
  localparam int STATUS_W      = 3;
  localparam int QN_W          = 7;
  localparam int MSG_NODES_W   = 6;
  localparam int MAX_LENGTH    = 504;
  localparam int MAX_MSG_NODES = 63;
  localparam int QN_RESET      = 64;

  localparam logic [1:0] ACT_PUSH     = 2'd0;
  localparam logic [1:0] ACT_POP      = 2'd1;
  localparam logic [1:0] ACT_SHUTDOWN = 2'd2;
  localparam logic [1:0] ACT_IGNORE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHUTDOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [DATA_W-1:0] segment_data;
    logic [LEN_W-1:0]  message_length;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   node_data;
    logic [VB_W-1:0]     valid_bytes;
    logic [LEN_W-1:0]    total_length;
    logic                last;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [VB_W-1:0]   byte_count;
  } slot_t;

  // Keeps the low 'bytes' bytes of a node.
  function automatic logic [DATA_W-1:0] byte_mask(logic [VB_W-1:0] bytes);
    logic [DATA_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (b < int'(bytes)) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

  // Byte count of the final node of a message of 'len' bytes.
  function automatic logic [VB_W-1:0] tail_bytes(logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = LEN_W'(int'(len) % NODE_BYTES);
    return (r == '0) ? VB_W'(NODE_BYTES) : VB_W'(r);
  endfunction

endpackage

@@ src/segmented_message_ring_queue.sv @@
// For a push, a shutdown and a pop of an empty ring, the result appears the cycle after
// the request is taken, and busy stays low, so a new request may follow at once.
// A pop of n nodes holds busy while the head count, then the last node's byte count
// are read and the nodes stream out one per cycle over the node store's single read port.
// Synchronous reset empties the ring, sets the ring size to 64 and clears shutdown; the node
// store keeps undefined contents, and only committed slots are ever read.
module segmented_message_ring_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  smrq_pkg::command_t                command,
  input  logic                              queue_nodes_we,
  input  logic [smrq_pkg::QN_W-1:0]         queue_nodes_data,
  output logic                              result_valid,
  output smrq_pkg::result_t                 result
);

  typedef enum logic [1:0] {S_IDLE, S_POP_COUNT, S_POP_LAST, S_POP_STREAM} state_t;

  localparam int IDX_W  = smrq_pkg::IDX_W;
  localparam int SIZE_W = smrq_pkg::SIZE_W;
  localparam int NREQ_W = smrq_pkg::LEN_W + 1;

  state_t                              state;
  logic [smrq_pkg::QN_W-1:0]           queue_nodes;
  logic [IDX_W-1:0]                    head_index;
  logic [IDX_W-1:0]                    committed_tail;
  logic [IDX_W-1:0]                    write_index;
  logic [smrq_pkg::MSG_NODES_W-1:0]    segments_left;
  logic                                dropping_message;
  logic [smrq_pkg::LEN_W-1:0]          pending_length;
  logic                                stopped;
  logic [IDX_W-1:0]                    pop_nodes;
  logic [IDX_W-1:0]                    remaining;
  logic [smrq_pkg::LEN_W-1:0]          pop_total;

  smrq_pkg::slot_t                     slot_mem [smrq_pkg::QUEUE_DEPTH];
  logic [smrq_pkg::MSG_NODES_W-1:0]    count_mem [smrq_pkg::QUEUE_DEPTH];
  smrq_pkg::slot_t                     slot_rd;
  logic [smrq_pkg::MSG_NODES_W-1:0]    count_rd;

  logic [SIZE_W-1:0]                   ring_size;
  logic [SIZE_W-1:0]                   used_wide;
  logic [IDX_W-1:0]                    used;
  logic [SIZE_W-1:0]                   free_nodes;
  logic [NREQ_W-1:0]                   nodes_req;
  logic                                accept;
  logic                                push_accept;
  logic                                first_ok;
  logic                                wr_en;
  logic                                count_wr_en;
  logic [IDX_W-1:0]                    wr_addr;
  logic [smrq_pkg::VB_W-1:0]           wr_bytes;
  logic [IDX_W-1:0]                    rd_addr;
  logic [IDX_W-1:0]                    head_inc;
  logic [IDX_W-1:0]                    tail_inc;
  logic [IDX_W-1:0]                    write_inc;
  logic [IDX_W-1:0]                    pop_nodes_calc;
  logic [IDX_W+1:0]                    last_sum;
  logic [IDX_W-1:0]                    last_slot;

  function automatic logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] idx,
                                               logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] n;
    n = {1'b0, idx} + SIZE_W'(1);
    return (n == size) ? '0 : n[IDX_W-1:0];
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign push_accept = accept && !stopped && (command.action == smrq_pkg::ACT_PUSH);

  always_comb begin
    if (int'(queue_nodes) < 2) begin
      ring_size = SIZE_W'(2);
    end else if (int'(queue_nodes) > smrq_pkg::QUEUE_DEPTH) begin
      ring_size = SIZE_W'(smrq_pkg::QUEUE_DEPTH);
    end else begin
      ring_size = SIZE_W'(queue_nodes);
    end
  end

  // Wrap-around in the sum cancels out, as the true occupancy is below the ring size.
  always_comb begin
    if (committed_tail >= head_index) begin
      used_wide = {1'b0, committed_tail} - {1'b0, head_index};
    end else begin
      used_wide = {1'b0, committed_tail} + ring_size - {1'b0, head_index};
    end
    used       = used_wide[IDX_W-1:0];
    free_nodes = ring_size - SIZE_W'(1) - {1'b0, used};
  end

  assign head_inc  = wrap_inc(head_index, ring_size);
  assign tail_inc  = wrap_inc(committed_tail, ring_size);
  assign write_inc = wrap_inc(write_index, ring_size);

  assign nodes_req = NREQ_W'((int'(command.message_length) + smrq_pkg::NODE_BYTES - 1)
                             / smrq_pkg::NODE_BYTES);

  assign first_ok = (command.message_length != '0)
                    && (int'(command.message_length) <= smrq_pkg::MAX_LENGTH)
                    && (int'(nodes_req) <= smrq_pkg::MAX_MSG_NODES)
                    && (int'(nodes_req) <= int'(free_nodes));

  // Store write: a continuing segment goes through the write pointer, a first one
  // lands on the committed tail.
  always_comb begin
    if (segments_left != '0) begin
      wr_en       = push_accept && !dropping_message;
      count_wr_en = 1'b0;
      wr_addr     = write_index;
      wr_bytes    = (segments_left == smrq_pkg::MSG_NODES_W'(1))
                    ? smrq_pkg::tail_bytes(pending_length)
                    : smrq_pkg::VB_W'(smrq_pkg::NODE_BYTES);
    end else begin
      wr_en       = push_accept && first_ok;
      count_wr_en = push_accept && first_ok;
      wr_addr     = committed_tail;
      wr_bytes    = (nodes_req == NREQ_W'(1))
                    ? smrq_pkg::tail_bytes(command.message_length)
                    : smrq_pkg::VB_W'(smrq_pkg::NODE_BYTES);
    end
  end

  // A head count that is zero or exceeds the number of committed nodes is treated as corrupt.
  always_comb begin
    if (count_rd == '0 || int'(count_rd) > int'(used)) begin
      pop_nodes_calc = used;
    end else begin
      pop_nodes_calc = IDX_W'(count_rd);
    end
    last_sum = {2'b00, head_index} + {2'b00, pop_nodes_calc} - (IDX_W+2)'(1);
    if (last_sum >= {1'b0, ring_size}) begin
      last_slot = IDX_W'(last_sum - {1'b0, ring_size});
    end else begin
      last_slot = last_sum[IDX_W-1:0];
    end
  end

  always_comb begin
    case (state)
      S_POP_COUNT:  rd_addr = last_slot;
      S_POP_LAST:   rd_addr = head_index;
      S_POP_STREAM: rd_addr = head_inc;
      default:      rd_addr = head_index;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= '{data: command.segment_data & smrq_pkg::byte_mask(wr_bytes),
                             byte_count: wr_bytes};
    end
    slot_rd <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (count_wr_en) begin
      count_mem[committed_tail] <= smrq_pkg::MSG_NODES_W'(nodes_req);
    end
    count_rd <= count_mem[head_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_valid     <= 1'b0;
      queue_nodes      <= smrq_pkg::QN_W'(smrq_pkg::QN_RESET);
      head_index       <= '0;
      committed_tail   <= '0;
      write_index      <= '0;
      segments_left    <= '0;
      dropping_message <= 1'b0;
      pending_length   <= '0;
      stopped          <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && command.action != smrq_pkg::ACT_IGNORE) begin
            result_valid        <= 1'b1;
            result.status       <= smrq_pkg::ST_OK;
            result.node_data    <= '0;
            result.valid_bytes  <= '0;
            result.total_length <= '0;
            result.last         <= 1'b1;
            if (stopped) begin
              result.status <= smrq_pkg::ST_SHUTDOWN;
            end else if (command.action == smrq_pkg::ACT_SHUTDOWN) begin
              stopped <= 1'b1;
            end else if (command.action == smrq_pkg::ACT_POP) begin
              if (used == '0) begin
                result.status <= smrq_pkg::ST_EMPTY;
              end else begin
                result_valid <= 1'b0;
                state        <= S_POP_COUNT;
              end
            end else if (segments_left != '0) begin
              segments_left <= segments_left - smrq_pkg::MSG_NODES_W'(1);
              if (dropping_message) begin
                result.status <= smrq_pkg::ST_NO_ROOM;
                if (segments_left == smrq_pkg::MSG_NODES_W'(1)) begin
                  dropping_message <= 1'b0;
                end
              end else begin
                write_index <= write_inc;
                if (segments_left == smrq_pkg::MSG_NODES_W'(1)) begin
                  committed_tail <= write_inc;
                end
              end
            end else if (command.message_length == '0
                         || int'(command.message_length) > smrq_pkg::MAX_LENGTH
                         || int'(nodes_req) > smrq_pkg::MAX_MSG_NODES) begin
              result.status <= smrq_pkg::ST_BAD_LEN;
            end else if (!first_ok) begin
              result.status <= smrq_pkg::ST_NO_ROOM;
              if (nodes_req > NREQ_W'(1)) begin
                dropping_message <= 1'b1;
                segments_left    <= smrq_pkg::MSG_NODES_W'(nodes_req - NREQ_W'(1));
              end
            end else begin
              pending_length <= command.message_length;
              write_index    <= tail_inc;
              segments_left  <= smrq_pkg::MSG_NODES_W'(nodes_req - NREQ_W'(1));
              if (nodes_req == NREQ_W'(1)) begin
                committed_tail <= tail_inc;
              end
            end
          end
        end
        S_POP_COUNT: begin
          pop_nodes <= pop_nodes_calc;
          state     <= S_POP_LAST;
        end
        S_POP_LAST: begin
          pop_total <= smrq_pkg::LEN_W'((int'(pop_nodes) - 1) * smrq_pkg::NODE_BYTES
                                        + int'(slot_rd.byte_count));
          remaining <= pop_nodes;
          state     <= S_POP_STREAM;
        end
        S_POP_STREAM: begin
          result_valid        <= 1'b1;
          result.status       <= smrq_pkg::ST_OK;
          result.node_data    <= slot_rd.data;
          result.valid_bytes  <= slot_rd.byte_count;
          result.total_length <= pop_total;
          result.last         <= (remaining == IDX_W'(1));
          head_index          <= head_inc;
          remaining           <= remaining - IDX_W'(1);
          if (remaining == IDX_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A resize empties the ring and abandons any message being written.
      if (queue_nodes_we) begin
        queue_nodes      <= queue_nodes_data;
        head_index       <= '0;
        committed_tail   <= '0;
        write_index      <= '0;
        segments_left    <= '0;
        dropping_message <= 1'b0;
        pending_length   <= '0;
      end
    end
  end

`include "segmented_message_ring_queue_assert.svh"

  `SMRQ_ASSERT_NEXT(a_stream_unbroken, clk, rst, result_valid && !result.last, result_valid, "pop stream broke before its last node")
  `SMRQ_ASSERT_IMPLY(a_busy_mid_stream, clk, rst, result_valid && !result.last, busy, "request taken in the middle of a pop")
  `SMRQ_ASSERT_IMPLY(a_pointers_in_ring, clk, rst, 1'b1, ({1'b0, head_index} < ring_size) && ({1'b0, committed_tail} < ring_size), "ring pointer beyond ring size")
  `SMRQ_ASSERT_NEXT(a_empty_pop, clk, rst, accept && !stopped && command.action == smrq_pkg::ACT_POP && used == '0, result_valid && result.status == smrq_pkg::ST_EMPTY, "pop of an empty ring not answered as empty")

endmodule

@@ sim/tb_segmented_message_ring_queue.sv @@
// Self-checking testbench for the segmented message ring queue: directed requests
// from a table, random message traffic over several ring sizes, then the rest of the table.
// Depends on smrq_pkg and the segmented_message_ring_queue RTL.
module tb_segmented_message_ring_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_REQUESTS = 4;
  localparam int DRILL_SPLIT    = 21;
  localparam int DRILL_ROWS     = 26;

  typedef struct packed {
    logic [1:0]                    action;
    logic [smrq_pkg::DATA_W-1:0]   data;
    logic [smrq_pkg::LEN_W-1:0]    length;
    logic                          typed;
    logic [smrq_pkg::STATUS_W-1:0] status;
  } drill_row_t;

  // Status is typed in only where it is plain; the other rows use the predictor.
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b1, smrq_pkg::ST_EMPTY},
    '{smrq_pkg::ACT_PUSH,     64'hFFFF_FFFF_FFFF_FFFF, 9'd0,   1'b1, smrq_pkg::ST_BAD_LEN},
    '{smrq_pkg::ACT_PUSH,     64'h0,                   9'd505, 1'b1, smrq_pkg::ST_BAD_LEN},
    '{smrq_pkg::ACT_PUSH,     64'hFFFF_FFFF_FFFF_FFFF, 9'd511, 1'b1, smrq_pkg::ST_BAD_LEN},
    '{smrq_pkg::ACT_IGNORE,   64'h1234_5678_9ABC_DEF0, 9'd12,  1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'hFFFF_FFFF_FFFF_FFFF, 9'd1,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'h0,                   9'd8,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'hFFFF_FFFF_FFFF_FFFF, 9'd511, 1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'h0123_4567_89AB_CDEF, 9'd9,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b1, smrq_pkg::ST_EMPTY},
    '{smrq_pkg::ACT_PUSH,     64'hFEDC_BA98_7654_3210, 9'd0,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'hA5A5_A5A5_A5A5_A5A5, 9'd17,  1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'h5A5A_5A5A_5A5A_5A5A, 9'd300, 1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'hDEAD_BEEF_CAFE_F00D, 9'd0,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'h8000_0000_0000_0001, 9'd3,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b1, smrq_pkg::ST_EMPTY},
    '{smrq_pkg::ACT_IGNORE,   64'hFFFF_FFFF_FFFF_FFFF, 9'd511, 1'b0, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_SHUTDOWN, 64'h0,                   9'd0,   1'b1, smrq_pkg::ST_OK},
    '{smrq_pkg::ACT_PUSH,     64'hFFFF_FFFF_FFFF_FFFF, 9'd8,   1'b1, smrq_pkg::ST_SHUTDOWN},
    '{smrq_pkg::ACT_POP,      64'h0,                   9'd0,   1'b1, smrq_pkg::ST_SHUTDOWN},
    '{smrq_pkg::ACT_SHUTDOWN, 64'h0,                   9'd0,   1'b1, smrq_pkg::ST_SHUTDOWN},
    '{smrq_pkg::ACT_IGNORE,   64'h0,                   9'd0,   1'b0, smrq_pkg::ST_OK}
  };

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  smrq_pkg::command_t        command;
  logic                      queue_nodes_we;
  logic [smrq_pkg::QN_W-1:0] queue_nodes_data;
  logic                      result_valid;
  smrq_pkg::result_t         result;

  segmented_message_ring_queue dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .queue_nodes_we   (queue_nodes_we),
    .queue_nodes_data (queue_nodes_data),
    .result_valid     (result_valid),
    .result           (result)
  );

  // Predicted ring contents and pointers.
  logic [smrq_pkg::DATA_W-1:0]      ring_data   [smrq_pkg::QUEUE_DEPTH];
  logic [smrq_pkg::VB_W-1:0]        ring_bytes  [smrq_pkg::QUEUE_DEPTH];
  logic [smrq_pkg::MSG_NODES_W-1:0] ring_counts [smrq_pkg::QUEUE_DEPTH];
  int unsigned ring_setting;
  int unsigned head_slot;
  int unsigned commit_slot;
  int unsigned write_slot;
  int unsigned segments_owed;
  bit          discarding;
  int unsigned message_bytes;
  bit          halted;

  smrq_pkg::result_t expected_results [$];
  int      requests_sent;
  int      results_seen;
  int      mismatches;
  int      idle_cycles;
  bit      steady;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned ring_size();
    if (ring_setting < 2) return 2;
    if (ring_setting > smrq_pkg::QUEUE_DEPTH) return smrq_pkg::QUEUE_DEPTH;
    return ring_setting;
  endfunction

  function automatic logic [smrq_pkg::DATA_W-1:0] keep_bytes(
      logic [smrq_pkg::DATA_W-1:0] d, int unsigned n);
    if (n >= 8) return d;
    return d & ((64'd1 << (n * 8)) - 64'd1);
  endfunction

  function automatic int unsigned last_node_bytes(int unsigned len);
    return (len % smrq_pkg::NODE_BYTES == 0) ? smrq_pkg::NODE_BYTES
                                             : len % smrq_pkg::NODE_BYTES;
  endfunction

  function automatic smrq_pkg::result_t status_only(logic [smrq_pkg::STATUS_W-1:0] st);
    smrq_pkg::result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void clear_ring();
    head_slot = 0;
    commit_slot = 0;
    write_slot = 0;
    segments_owed = 0;
    discarding = 1'b0;
    message_bytes = 0;
  endfunction

  function automatic void write_node(logic [smrq_pkg::DATA_W-1:0] d, int unsigned n,
                                     int unsigned sz);
    int unsigned w;
    w = write_slot % sz;
    ring_data[w] = keep_bytes(d, n);
    ring_bytes[w] = smrq_pkg::VB_W'(n);
    write_slot = (w + 1) % sz;
  endfunction

  // Works out the results of one request and advances the predicted state.
  function automatic void predict_request(input smrq_pkg::command_t c,
                                          ref smrq_pkg::result_t out[$]);
    int unsigned sz, used, nodes, last_slot, total, vb, len;
    smrq_pkg::result_t r;
    len = c.message_length;
    if (c.action == smrq_pkg::ACT_IGNORE) return;
    if (halted) begin
      out.push_back(status_only(smrq_pkg::ST_SHUTDOWN));
      return;
    end
    if (c.action == smrq_pkg::ACT_SHUTDOWN) begin
      halted = 1'b1;
      out.push_back(status_only(smrq_pkg::ST_OK));
      return;
    end
    sz = ring_size();
    used = (commit_slot + sz - head_slot) % sz;
    if (c.action == smrq_pkg::ACT_POP) begin
      if (used == 0) begin
        out.push_back(status_only(smrq_pkg::ST_EMPTY));
        return;
      end
      // A damaged head count falls back to everything committed.
      nodes = ring_counts[head_slot];
      if (nodes == 0 || nodes > used) nodes = used;
      last_slot = (head_slot + nodes - 1) % sz;
      total = (nodes - 1) * smrq_pkg::NODE_BYTES + ring_bytes[last_slot];
      for (int i = 0; i < nodes; i++) begin
        vb = ring_bytes[head_slot];
        r.status = smrq_pkg::ST_OK;
        r.node_data = keep_bytes(ring_data[head_slot], vb);
        r.valid_bytes = smrq_pkg::VB_W'(vb);
        r.total_length = smrq_pkg::LEN_W'(total);
        r.last = (i + 1 == nodes);
        out.push_back(r);
        head_slot = (head_slot + 1) % sz;
      end
      return;
    end
    if (segments_owed > 0) begin
      if (discarding) begin
        segments_owed--;
        if (segments_owed == 0) discarding = 1'b0;
        out.push_back(status_only(smrq_pkg::ST_NO_ROOM));
        return;
      end
      write_node(c.segment_data,
                 segments_owed == 1 ? last_node_bytes(message_bytes) : smrq_pkg::NODE_BYTES,
                 sz);
      segments_owed--;
      if (segments_owed == 0) commit_slot = write_slot;
      out.push_back(status_only(smrq_pkg::ST_OK));
      return;
    end
    nodes = (len + smrq_pkg::NODE_BYTES - 1) / smrq_pkg::NODE_BYTES;
    if (len == 0 || len > smrq_pkg::MAX_LENGTH || nodes > smrq_pkg::MAX_MSG_NODES) begin
      out.push_back(status_only(smrq_pkg::ST_BAD_LEN));
      return;
    end
    if (nodes > sz - 1 - used) begin
      // The rest of a refused message is swallowed segment by segment.
      if (nodes > 1) begin
        discarding = 1'b1;
        segments_owed = nodes - 1;
      end
      out.push_back(status_only(smrq_pkg::ST_NO_ROOM));
      return;
    end
    write_slot = commit_slot;
    ring_counts[write_slot] = smrq_pkg::MSG_NODES_W'(nodes);
    message_bytes = len;
    write_node(c.segment_data, nodes == 1 ? last_node_bytes(len) : smrq_pkg::NODE_BYTES, sz);
    segments_owed = nodes - 1;
    if (segments_owed == 0) commit_slot = write_slot;
    out.push_back(status_only(smrq_pkg::ST_OK));
  endfunction

  // Presents one request, holds it until taken, then idles for a drawn gap (none when steady).
  task automatic issue(input smrq_pkg::command_t c, input bit typed = 1'b0,
                       input logic [smrq_pkg::STATUS_W-1:0] typed_status = smrq_pkg::ST_OK);
    smrq_pkg::result_t predicted [$];
    int gap;
    start <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(c, predicted);
    if (typed) expected_results.push_back(status_only(typed_status));
    else foreach (predicted[i]) expected_results.push_back(predicted[i]);
    if (c.action != smrq_pkg::ACT_IGNORE) requests_sent++;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue_op(input logic [1:0] act, input int unsigned len);
    smrq_pkg::command_t c;
    c.action = act;
    c.segment_data = {$urandom, $urandom};
    c.message_length = smrq_pkg::LEN_W'(len);
    issue(c);
  endtask

  // Pushes a message segment by segment; a cut message may leave its tail unsent.
  task automatic push_message(input int unsigned len, input bit cut);
    int unsigned segs;
    segs = (len + smrq_pkg::NODE_BYTES - 1) / smrq_pkg::NODE_BYTES;
    if (segs == 0) segs = 1;
    if (cut) segs = $urandom_range(1, segs);
    for (int k = 0; k < segs; k++) begin
      if (k > 0 && $urandom_range(0, 9) == 0) issue_op(smrq_pkg::ACT_POP, 0);
      issue_op(smrq_pkg::ACT_PUSH, k == 0 ? len : $urandom_range(0, 511));
    end
  endtask

  task automatic random_step();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      push_message($urandom_range(0, 9) != 0 ? $urandom_range(1, 40) : $urandom_range(41, 504),
                   $urandom_range(0, 19) == 0);
    end else if (pick < 85) begin
      issue_op(smrq_pkg::ACT_POP, 0);
    end else if (pick < 90) begin
      issue_op(smrq_pkg::ACT_IGNORE, $urandom_range(0, 511));
    end else if (pick < 95) begin
      issue_op(smrq_pkg::ACT_PUSH, 0);
    end else begin
      issue_op(smrq_pkg::ACT_PUSH, $urandom_range(505, 511));
    end
  endtask

  // Waits for the block to drain, then writes the ring size.
  task automatic set_ring(input int unsigned v);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    queue_nodes_we <= 1'b1;
    queue_nodes_data <= smrq_pkg::QN_W'(v);
    @(posedge clk);
    queue_nodes_we <= 1'b0;
    ring_setting = v;
    clear_ring();
  endtask

  task automatic note_mismatch(input string what, input smrq_pkg::result_t want,
                               input smrq_pkg::result_t got);
    if (mismatches < 10) begin
      $display("%s: expected st=%0d data=%h vb=%0d len=%0d last=%0b, got st=%0d data=%h vb=%0d len=%0d last=%0b",
               what, want.status, want.node_data, want.valid_bytes, want.total_length,
               want.last, got.status, got.node_data, got.valid_bytes, got.total_length,
               got.last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    smrq_pkg::result_t want;
    if (!rst && result_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch("Result with nothing outstanding", '0, result);
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status || result.node_data !== want.node_data ||
            result.valid_bytes !== want.valid_bytes ||
            result.total_length !== want.total_length || result.last !== want.last) begin
          note_mismatch("Result mismatch", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", expected_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned ring_settings [9];
    int unsigned eff;
    int target;
    ring_settings = '{2, 0, 1, 3, 127, 5, 9, 17, 64};
    rst = 1'b1;
    start = 1'b0;
    command = '0;
    queue_nodes_we = 1'b0;
    queue_nodes_data = '0;
    idle_cycles = 0;
    requests_sent = 0;
    results_seen = 0;
    mismatches = 0;
    steady = 1'b0;
    ring_setting = smrq_pkg::QN_RESET;
    halted = 1'b0;
    clear_ring();
    for (int i = 0; i < smrq_pkg::QUEUE_DEPTH; i++) begin
      ring_data[i] = '0;
      ring_bytes[i] = '0;
      ring_counts[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DRILL_SPLIT; i++) begin
      issue('{DRILL[i].action, DRILL[i].data, DRILL[i].length}, DRILL[i].typed, DRILL[i].status);
    end

    foreach (ring_settings[p]) begin
      set_ring(ring_settings[p]);
      steady = ($urandom_range(0, 3) == 0);
      eff = ring_size();
      // Fill the ring exactly, knock on a full ring, then drain one message.
      push_message((eff - 1) * smrq_pkg::NODE_BYTES > smrq_pkg::MAX_LENGTH
                   ? smrq_pkg::MAX_LENGTH : (eff - 1) * smrq_pkg::NODE_BYTES,
                   1'b0);
      issue_op(smrq_pkg::ACT_PUSH, 1);
      issue_op(smrq_pkg::ACT_POP, 0);
      target = requests_sent + PHASE_REQUESTS;
      while (requests_sent < target) random_step();
    end

    steady = 1'b0;
    for (int i = DRILL_SPLIT; i < DRILL_ROWS; i++) begin
      issue('{DRILL[i].action, DRILL[i].data, DRILL[i].length}, DRILL[i].typed, DRILL[i].status);
    end
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests across %0d ring sizes plus shutdown; checked %0d results.",
             requests_sent, $size(ring_settings), results_seen);
    $display("Mismatching results: %0d", mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/smrq_pkg.sv
src/segmented_message_ring_queue.sv
sim/tb_segmented_message_ring_queue.sv
